/* rtl/core/rdoq_pkg.sv */
// Shared types, widths and the helper function of the rate-distortion optimized quantizer.
package rdoq_pkg;

   localparam int COEF_W       = 16;
   localparam int STEP_W       = 16;
   localparam int WEIGHT_W     = 24;
   localparam int LEVEL_W      = 16;
   localparam int MAG_W        = 17;
   localparam int BITS_W       = 6;
   localparam int PROD_W       = WEIGHT_W + STEP_W;
   localparam int SQUARE_W     = 2 * STEP_W;
   localparam int CAND_COST_W  = 41;
   localparam int ITEM_COST_W  = 40;
   localparam int BLOCK_COST_W = 50;
   localparam int DIV_COUNT_W  = 4;
   localparam int RSP_DATA_W   = 112;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 24;

   localparam logic [STEP_W-1:0]       QUANT_STEP_RESET  = 16'd1;
   localparam logic [WEIGHT_W-1:0]     RATE_WEIGHT_RESET = 24'd256;
   localparam logic [BLOCK_COST_W-1:0] BLOCK_COST_MAX    = {BLOCK_COST_W{1'b1}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUANT_STEP  = 1'b0,
      CSR_RATE_WEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SQUARE,
      ST_RATE,
      ST_COMPARE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      CAND_ZERO,
      CAND_FLOOR,
      CAND_CEIL
   } cand_type;

   typedef enum logic [1:0] {
      COST_HOLD,
      COST_SQUARE,
      COST_RATE
   } cost_op_type;

   typedef struct packed {
      logic [STEP_W-1:0] quotient;
      logic [STEP_W-1:0] remainder;
      logic              done;
   } div_result_type;

   // Rate of a level from its magnitude: 0, 3, or 2*floor(log2(mag+1))+2.
   function automatic logic [BITS_W-1:0] level_bits(input logic [MAG_W-1:0] mag);
      logic [MAG_W:0]    val;
      logic [BITS_W-1:0] msb;
      logic [BITS_W-1:0] result;
      val = {1'b0, mag} + {{MAG_W{1'b0}}, 1'b1};
      msb = '0;
      for (int i = 0; i <= MAG_W; i++) begin
         if (val[i]) begin
            msb = BITS_W'(i);
         end
      end
      if (mag == '0) begin
         result = '0;
      end else if (mag == {{(MAG_W-1){1'b0}}, 1'b1}) begin
         result = BITS_W'(3);
      end else begin
         result = BITS_W'({msb, 1'b0} + BITS_W'(2));
      end
      return result;
   endfunction

endpackage

/* rtl/core/rdoq_divider.sv */
// Serial restoring divider: one quotient bit per cycle for an unsigned 16-bit dividend.
module rdoq_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rdoq_pkg::STEP_W-1:0]   dividend,
   input  logic [rdoq_pkg::STEP_W-1:0]   divisor,
   output rdoq_pkg::div_result_type      result
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [rdoq_pkg::DIV_COUNT_W-1:0]    count_ff, count_in;
   logic [rdoq_pkg::STEP_W-1:0]         rem_ff, rem_in;
   logic [rdoq_pkg::STEP_W-1:0]         work_ff, work_in;
   logic [rdoq_pkg::STEP_W-1:0]         divisor_ff, divisor_in;
   logic [rdoq_pkg::STEP_W:0]           trial;
   logic [rdoq_pkg::STEP_W:0]           diff;
   logic                                fits;

   always_comb begin
      trial   = {rem_ff, work_ff[rdoq_pkg::STEP_W-1]};
      diff    = trial - {1'b0, divisor_ff};
      fits    = trial >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      work_in    = work_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         work_in    = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[rdoq_pkg::STEP_W-1:0] : trial[rdoq_pkg::STEP_W-1:0];
         work_in  = {work_ff[rdoq_pkg::STEP_W-2:0], fits};
         count_in = count_ff + rdoq_pkg::DIV_COUNT_W'(1);
         if (count_ff == {rdoq_pkg::DIV_COUNT_W{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      work_ff    <= work_in;
      divisor_ff <= divisor_in;
   end

   assign result.quotient  = work_ff;
   assign result.remainder = rem_ff;
   assign result.done      = done_ff;

endmodule

/* rtl/core/rdoq_cost_unit.sv */
// Shared multiplier that forms a candidate cost as squared error times 256 plus weighted rate.
module rdoq_cost_unit (
   input  logic                              clock,
   input  rdoq_pkg::cost_op_type             op,
   input  logic [rdoq_pkg::STEP_W-1:0]       distance,
   input  logic [rdoq_pkg::WEIGHT_W-1:0]     weight,
   input  logic [rdoq_pkg::BITS_W-1:0]       rate_bits,
   output logic [rdoq_pkg::CAND_COST_W-1:0]  cost
);

   logic [rdoq_pkg::WEIGHT_W-1:0] mul_a;
   logic [rdoq_pkg::STEP_W-1:0]   mul_b;
   logic [rdoq_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [rdoq_pkg::SQUARE_W-1:0] square_ff, square_in;

   always_comb begin
      mul_a     = rdoq_pkg::WEIGHT_W'(distance);
      mul_b     = distance;
      prod_in   = prod_ff;
      square_in = square_ff;
      unique case (op)
         rdoq_pkg::COST_SQUARE: begin
            prod_in = mul_a * mul_b;
         end
         rdoq_pkg::COST_RATE: begin
            // The squared error moves aside while the multiplier forms the rate term.
            mul_a     = weight;
            mul_b     = rdoq_pkg::STEP_W'(rate_bits);
            square_in = prod_ff[rdoq_pkg::SQUARE_W-1:0];
            prod_in   = mul_a * mul_b;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      square_ff <= square_in;
   end

   assign cost = {1'b0, square_ff, 8'b0} + rdoq_pkg::CAND_COST_W'(prod_ff);

endmodule

/* rtl/core/rd_optimized_quantizer_unit.sv */
// Top level of the rate-distortion optimized quantizer: sequencer, block total and ports.
//
// Each coefficient item is divided by quant_step in a serial restoring divider, after which up
// to three candidate levels (zero, floor and ceiling of the quotient) are costed one after
// another on a single shared multiplier, in three steps per candidate: squared error, rate
// term, then add and compare. The chosen result then moves into the output register once that
// register is free. Only distinct candidates are costed, from one to three per item.
// req_tready is high only while the sequencer is idle; a finished result waits in the output
// register, so the next item can be taken before the previous result is drained.
// The cost of the chosen level is reported with a running block total that saturates at
// 2^50-1 and returns to zero after the item flagged by req_tlast. A quant_step of zero behaves
// as one. Configuration writes are always accepted and must only be issued while idle.
module rd_optimized_quantizer_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration write channel.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rdoq_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rdoq_pkg::CSR_DATA_W-1:0]       csr_data,
   // Input item channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rdoq_pkg::COEF_W-1:0]           req_tdata,  // [15:0] coefficient
   input  logic                                  req_tlast,  // last_in
   // Result item channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rdoq_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // [15:0] level, [55:16] item_cost,
                                                             // [105:56] block_cost, rest zero
   output logic                                  rsp_tlast   // last_out
);

   // Configuration registers.
   logic [rdoq_pkg::STEP_W-1:0]        quant_step_ff, quant_step_in;
   logic [rdoq_pkg::WEIGHT_W-1:0]      rate_weight_ff, rate_weight_in;
   logic [rdoq_pkg::STEP_W-1:0]        step_eff;

   // Sequencer state.
   rdoq_pkg::state_type                state_ff, state_in;
   rdoq_pkg::cand_type                 cand_ff, cand_in;

   // Per-item working registers.
   logic                               neg_ff, neg_in;
   logic                               last_ff, last_in;
   logic [rdoq_pkg::STEP_W-1:0]        coef_mag_ff, coef_mag_in;
   logic [rdoq_pkg::LEVEL_W-1:0]       floor_level_ff, floor_level_in;
   logic [rdoq_pkg::LEVEL_W-1:0]       ceil_level_ff, ceil_level_in;
   logic [rdoq_pkg::MAG_W-1:0]         floor_mag_ff, floor_mag_in;
   logic [rdoq_pkg::MAG_W-1:0]         ceil_mag_ff, ceil_mag_in;
   logic [rdoq_pkg::STEP_W-1:0]        floor_dist_ff, floor_dist_in;
   logic [rdoq_pkg::STEP_W-1:0]        ceil_dist_ff, ceil_dist_in;
   logic                               floor_ok_ff, floor_ok_in;
   logic                               ceil_ok_ff, ceil_ok_in;
   logic [rdoq_pkg::LEVEL_W-1:0]       best_level_ff, best_level_in;
   logic [rdoq_pkg::CAND_COST_W-1:0]   best_cost_ff, best_cost_in;

   // Block total and output register.
   logic [rdoq_pkg::BLOCK_COST_W-1:0]  total_ff, total_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rdoq_pkg::LEVEL_W-1:0]       rsp_level_ff, rsp_level_in;
   logic [rdoq_pkg::ITEM_COST_W-1:0]   rsp_item_ff, rsp_item_in;
   logic [rdoq_pkg::BLOCK_COST_W-1:0]  rsp_block_ff, rsp_block_in;
   logic                               rsp_last_ff, rsp_last_in;

   // Datapath helpers.
   logic                               req_accept;
   logic [rdoq_pkg::STEP_W-1:0]        req_mag;
   rdoq_pkg::div_result_type           div_result;
   logic [rdoq_pkg::MAG_W-1:0]         quot_plus;
   logic [rdoq_pkg::STEP_W-1:0]        step_minus_rem;
   logic                               rem_nonzero;
   rdoq_pkg::cost_op_type              cost_op;
   logic [rdoq_pkg::STEP_W-1:0]        cand_dist;
   logic [rdoq_pkg::MAG_W-1:0]         cand_mag;
   logic [rdoq_pkg::LEVEL_W-1:0]       cand_level;
   logic [rdoq_pkg::CAND_COST_W-1:0]   cand_cost;
   logic [rdoq_pkg::BLOCK_COST_W:0]    total_sum;
   logic [rdoq_pkg::BLOCK_COST_W-1:0]  total_sat;
   logic                               out_free;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == rdoq_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign step_eff   = (quant_step_ff == '0) ? rdoq_pkg::STEP_W'(1) : quant_step_ff;

   // Magnitude of the incoming coefficient; the most negative value maps to 0x8000.
   assign req_mag = req_tdata[rdoq_pkg::COEF_W-1] ? (~req_tdata + rdoq_pkg::STEP_W'(1))
                                                  : req_tdata;

   // Configuration writes.
   always_comb begin
      quant_step_in  = quant_step_ff;
      rate_weight_in = rate_weight_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == rdoq_pkg::CSR_QUANT_STEP) begin
            quant_step_in = csr_data[rdoq_pkg::STEP_W-1:0];
         end else if (csr_index == rdoq_pkg::CSR_RATE_WEIGHT) begin
            rate_weight_in = csr_data;
         end
      end
   end

   rdoq_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .dividend (req_mag),
      .divisor  (step_eff),
      .result   (div_result)
   );

   // Candidate levels from the unsigned quotient and remainder. The distances to the floor and
   // ceiling reconstruction points are the remainder and the step minus the remainder.
   assign quot_plus      = {1'b0, div_result.quotient} + rdoq_pkg::MAG_W'(1);
   assign step_minus_rem = step_eff - div_result.remainder;
   assign rem_nonzero    = (div_result.remainder != '0);

   // Operands of the candidate now being costed.
   always_comb begin
      unique case (cand_ff)
         rdoq_pkg::CAND_FLOOR: begin
            cand_dist  = floor_dist_ff;
            cand_mag   = floor_mag_ff;
            cand_level = floor_level_ff;
         end
         rdoq_pkg::CAND_CEIL: begin
            cand_dist  = ceil_dist_ff;
            cand_mag   = ceil_mag_ff;
            cand_level = ceil_level_ff;
         end
         default: begin
            cand_dist  = coef_mag_ff;
            cand_mag   = '0;
            cand_level = '0;
         end
      endcase
   end

   rdoq_cost_unit u_cost_unit (
      .clock     (clock),
      .op        (cost_op),
      .distance  (cand_dist),
      .weight    (rate_weight_ff),
      .rate_bits (rdoq_pkg::level_bits(cand_mag)),
      .cost      (cand_cost)
   );

   // Saturating block total including the chosen cost.
   assign total_sum = {1'b0, total_ff} + rdoq_pkg::BLOCK_COST_W'(best_cost_ff) +
                      (rdoq_pkg::BLOCK_COST_W + 1)'(0);
   assign total_sat = total_sum[rdoq_pkg::BLOCK_COST_W] ? rdoq_pkg::BLOCK_COST_MAX
                                                         : total_sum[rdoq_pkg::BLOCK_COST_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Sequencer: next state and working registers.
   always_comb begin
      state_in       = state_ff;
      cand_in        = cand_ff;
      neg_in         = neg_ff;
      last_in        = last_ff;
      coef_mag_in    = coef_mag_ff;
      floor_level_in = floor_level_ff;
      ceil_level_in  = ceil_level_ff;
      floor_mag_in   = floor_mag_ff;
      ceil_mag_in    = ceil_mag_ff;
      floor_dist_in  = floor_dist_ff;
      ceil_dist_in   = ceil_dist_ff;
      floor_ok_in    = floor_ok_ff;
      ceil_ok_in     = ceil_ok_ff;
      best_level_in  = best_level_ff;
      best_cost_in   = best_cost_ff;
      total_in       = total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_level_in   = rsp_level_ff;
      rsp_item_in    = rsp_item_ff;
      rsp_block_in   = rsp_block_ff;
      rsp_last_in    = rsp_last_ff;
      cost_op        = rdoq_pkg::COST_HOLD;

      unique case (state_ff)
         rdoq_pkg::ST_IDLE: begin
            if (req_accept) begin
               neg_in      = req_tdata[rdoq_pkg::COEF_W-1];
               last_in     = req_tlast;
               coef_mag_in = req_mag;
               state_in    = rdoq_pkg::ST_DIVIDE;
            end
         end
         rdoq_pkg::ST_DIVIDE: begin
            if (div_result.done) begin
               if (!neg_ff) begin
                  floor_mag_in  = {1'b0, div_result.quotient};
                  floor_dist_in = div_result.remainder;
                  ceil_mag_in   = quot_plus;
                  ceil_dist_in  = step_minus_rem;
               end else if (rem_nonzero) begin
                  floor_mag_in  = quot_plus;
                  floor_dist_in = step_minus_rem;
                  ceil_mag_in   = {1'b0, div_result.quotient};
                  ceil_dist_in  = div_result.remainder;
               end else begin
                  floor_mag_in  = {1'b0, div_result.quotient};
                  floor_dist_in = '0;
                  ceil_mag_in   = {1'b0, div_result.quotient};
                  ceil_dist_in  = '0;
               end
               floor_level_in = neg_ff ? (~floor_mag_in[rdoq_pkg::LEVEL_W-1:0] +
                                          rdoq_pkg::LEVEL_W'(1))
                                       : floor_mag_in[rdoq_pkg::LEVEL_W-1:0];
               ceil_level_in  = neg_ff ? (~ceil_mag_in[rdoq_pkg::LEVEL_W-1:0] +
                                          rdoq_pkg::LEVEL_W'(1))
                                       : ceil_mag_in[rdoq_pkg::LEVEL_W-1:0];
               // Duplicate candidates are skipped: a zero floor, and a ceiling that is zero
               // or equal to the floor when the division is exact.
               floor_ok_in = (floor_mag_in != '0);
               ceil_ok_in  = rem_nonzero && (ceil_mag_in != '0);
               cand_in     = rdoq_pkg::CAND_ZERO;
               state_in    = rdoq_pkg::ST_SQUARE;
            end
         end
         rdoq_pkg::ST_SQUARE: begin
            cost_op  = rdoq_pkg::COST_SQUARE;
            state_in = rdoq_pkg::ST_RATE;
         end
         rdoq_pkg::ST_RATE: begin
            cost_op  = rdoq_pkg::COST_RATE;
            state_in = rdoq_pkg::ST_COMPARE;
         end
         rdoq_pkg::ST_COMPARE: begin
            // The zero candidate seeds the search; later ones must be strictly cheaper.
            if (cand_ff == rdoq_pkg::CAND_ZERO || cand_cost < best_cost_ff) begin
               best_cost_in  = cand_cost;
               best_level_in = cand_level;
            end
            state_in = rdoq_pkg::ST_DONE;
            if (cand_ff == rdoq_pkg::CAND_ZERO && floor_ok_ff) begin
               cand_in  = rdoq_pkg::CAND_FLOOR;
               state_in = rdoq_pkg::ST_SQUARE;
            end else if (cand_ff != rdoq_pkg::CAND_CEIL && ceil_ok_ff) begin
               cand_in  = rdoq_pkg::CAND_CEIL;
               state_in = rdoq_pkg::ST_SQUARE;
            end
         end
         rdoq_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = best_level_ff;
               rsp_item_in  = best_cost_ff[rdoq_pkg::ITEM_COST_W-1:0];
               rsp_block_in = total_sat;
               rsp_last_in  = last_ff;
               total_in     = last_ff ? '0 : total_sat;
               state_in     = rdoq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rdoq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rdoq_pkg::ST_IDLE;
         cand_ff        <= rdoq_pkg::CAND_ZERO;
         quant_step_ff  <= rdoq_pkg::QUANT_STEP_RESET;
         rate_weight_ff <= rdoq_pkg::RATE_WEIGHT_RESET;
         total_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cand_ff        <= cand_in;
         quant_step_ff  <= quant_step_in;
         rate_weight_ff <= rate_weight_in;
         total_ff       <= total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      neg_ff         <= neg_in;
      last_ff        <= last_in;
      coef_mag_ff    <= coef_mag_in;
      floor_level_ff <= floor_level_in;
      ceil_level_ff  <= ceil_level_in;
      floor_mag_ff   <= floor_mag_in;
      ceil_mag_ff    <= ceil_mag_in;
      floor_dist_ff  <= floor_dist_in;
      ceil_dist_ff   <= ceil_dist_in;
      floor_ok_ff    <= floor_ok_in;
      ceil_ok_ff     <= ceil_ok_in;
      best_level_ff  <= best_level_in;
      best_cost_ff   <= best_cost_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_item_ff    <= rsp_item_in;
      rsp_block_ff   <= rsp_block_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(rdoq_pkg::RSP_DATA_W - rdoq_pkg::LEVEL_W - rdoq_pkg::ITEM_COST_W -
                          rdoq_pkg::BLOCK_COST_W){1'b0}},
                        rsp_block_ff, rsp_item_ff, rsp_level_ff};

endmodule
